### rtl/bpfm_pkg.sv
// ----------------------------------------------------------------------------
// bpfm_pkg
// Shared types and constants of the bar and peak falloff meter.
// ----------------------------------------------------------------------------
package bpfm_pkg;

   localparam int BAND_W  = 5;
   localparam int LEVEL_W = 16;
   localparam int LVL_W   = 8;
   localparam int HOLD_W  = 6;
   localparam int CMP_W   = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [HOLD_W-1:0] RST_BAR_FALLOFF  = 6'd4;
   localparam logic [HOLD_W-1:0] RST_BAR_HOLD     = 6'd1;
   localparam logic [HOLD_W-1:0] RST_PEAK_FALLOFF = 6'd1;
   localparam logic [HOLD_W-1:0] RST_PEAK_HOLD    = 6'd16;
   localparam logic [LVL_W-1:0]  RST_FULL_SCALE   = 8'd40;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BAR_FALLOFF  = 3'd0,
      CSR_BAR_HOLD     = 3'd1,
      CSR_PEAK_FALLOFF = 3'd2,
      CSR_PEAK_HOLD    = 3'd3,
      CSR_FULL_SCALE   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [HOLD_W-1:0] bar_falloff;
      logic [HOLD_W-1:0] bar_hold;
      logic [HOLD_W-1:0] peak_falloff;
      logic [HOLD_W-1:0] peak_hold;
      logic [LVL_W-1:0]  full_scale;
   } cfg_type;

   typedef struct packed {
      logic [LVL_W-1:0]  bar;
      logic [HOLD_W-1:0] bar_hold;
      logic [LVL_W-1:0]  peak;
      logic [HOLD_W-1:0] peak_hold;
   } band_state_type;

endpackage

### rtl/bpfm_band_update.sv
// ----------------------------------------------------------------------------
// bpfm_band_update
// Clamps a new level and applies bar and peak ballistics to one band, or clears its state.
// ----------------------------------------------------------------------------
module bpfm_band_update (
   input  bpfm_pkg::cfg_type                 cfg,
   input  bpfm_pkg::band_state_type          cur_state,
   input  logic signed [bpfm_pkg::LEVEL_W-1:0] level,
   input  logic                              clear,
   output bpfm_pkg::band_state_type          new_state
);
   import bpfm_pkg::*;

   typedef struct packed {
      logic [LVL_W-1:0]  lvl;
      logic [HOLD_W-1:0] hold;
   } kept_type;

   function automatic kept_type ballistics(
      input logic [LVL_W-1:0]  lvl,
      input logic [HOLD_W-1:0] hold,
      input logic [LVL_W-1:0]  x,
      input logic [HOLD_W-1:0] falloff,
      input logic [HOLD_W-1:0] reload
   );
      logic [HOLD_W-1:0] drop;
      logic [LVL_W-1:0]  cur;
      logic [HOLD_W-1:0] h;
      kept_type          res;
      drop = (falloff > hold) ? (falloff - hold) : '0;
      cur  = (lvl > LVL_W'(drop)) ? (lvl - LVL_W'(drop)) : '0;
      h    = (hold != '0) ? (hold - HOLD_W'(1)) : '0;
      if (x > cur) begin
         cur = x;
         h   = reload;
      end
      res.lvl  = cur;
      res.hold = h;
      return res;
   endfunction

   logic [LVL_W-1:0] x;
   kept_type         bar_res;
   kept_type         peak_res;

   always_comb begin
      if (level[LEVEL_W-1]) begin
         x = '0;
      end else if (level[LEVEL_W-2:0] > (LEVEL_W-1)'(cfg.full_scale)) begin
         x = cfg.full_scale;
      end else begin
         x = level[LVL_W-1:0];
      end
   end

   assign bar_res  = ballistics(cur_state.bar, cur_state.bar_hold, x,
                                cfg.bar_falloff, cfg.bar_hold);
   assign peak_res = ballistics(cur_state.peak, cur_state.peak_hold, x,
                                cfg.peak_falloff, cfg.peak_hold);

   always_comb begin
      if (clear) begin
         new_state = '0;
      end else begin
         new_state.bar       = bar_res.lvl;
         new_state.bar_hold  = bar_res.hold;
         new_state.peak      = peak_res.lvl;
         new_state.peak_hold = peak_res.hold;
      end
   end

endmodule

### rtl/bar_and_peak_falloff_meter_core.sv
// ----------------------------------------------------------------------------
// bar_and_peak_falloff_meter_core
// Per-band bar and peak display ballistics with hold and falloff.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  band, level, clear
//   rsp      out        rsp_valid / rsp_stall  band_out, bar_level, peak_level
//   csr      in         csr_valid / csr_ready  index, data
//
// One transaction per cycle unless rsp_stall; accept loads s1, then rsp regs.
// Band state sits in a memory read at accept; a same-band write is forwarded.
// Reset clears one valid bit per band at once; no clearing pass.
// rsp_stall holds the output register and the update stage, then req_stall.
// ----------------------------------------------------------------------------
module bar_and_peak_falloff_meter_core #(
   parameter int NUM_BANDS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [bpfm_pkg::BAND_W-1:0]           req_band,
   input  logic signed [bpfm_pkg::LEVEL_W-1:0]   req_level,
   input  logic                                  req_clear,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bpfm_pkg::BAND_W-1:0]           rsp_band_out,
   output logic [bpfm_pkg::LVL_W-1:0]            rsp_bar_level,
   output logic [bpfm_pkg::LVL_W-1:0]            rsp_peak_level,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bpfm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bpfm_pkg::CSR_DATA_W-1:0]       csr_data
);
   import bpfm_pkg::*;

   localparam int ADDR_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

   cfg_type cfg_ff;

   band_state_type mem [NUM_BANDS];
   logic [NUM_BANDS-1:0] vld_ff;

   logic                     s1_valid_ff, s1_valid_in;
   logic [BAND_W-1:0]        s1_band_ff;
   logic signed [LEVEL_W-1:0] s1_level_ff;
   logic                     s1_clear_ff;
   band_state_type           rd_ff;
   logic                     rd_vld_ff;
   logic                     fwd_ff;
   band_state_type           fwd_state_ff;

   logic                     rsp_valid_ff;
   logic [BAND_W-1:0]        rsp_band_ff;
   logic [LVL_W-1:0]         rsp_bar_ff;
   logic [LVL_W-1:0]         rsp_peak_ff;

   logic            accept, adv, s1_write, s1_in_range, req_fwd;
   logic [ADDR_W-1:0] req_addr, s1_addr;
   band_state_type  cur_state, new_state;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bar_falloff  <= RST_BAR_FALLOFF;
         cfg_ff.bar_hold     <= RST_BAR_HOLD;
         cfg_ff.peak_falloff <= RST_PEAK_FALLOFF;
         cfg_ff.peak_hold    <= RST_PEAK_HOLD;
         cfg_ff.full_scale   <= RST_FULL_SCALE;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BAR_FALLOFF:  cfg_ff.bar_falloff  <= csr_data[HOLD_W-1:0];
            CSR_BAR_HOLD:     cfg_ff.bar_hold     <= csr_data[HOLD_W-1:0];
            CSR_PEAK_FALLOFF: cfg_ff.peak_falloff <= csr_data[HOLD_W-1:0];
            CSR_PEAK_HOLD:    cfg_ff.peak_hold    <= csr_data[HOLD_W-1:0];
            CSR_FULL_SCALE:   cfg_ff.full_scale   <= csr_data[LVL_W-1:0];
            default: ;
         endcase
      end
   end

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !adv;
   assign accept    = req_valid && !req_stall;

   assign req_addr    = ADDR_W'(req_band);
   assign s1_addr     = ADDR_W'(s1_band_ff);
   assign s1_in_range = CMP_W'(s1_band_ff) < CMP_W'(NUM_BANDS);
   assign s1_write    = s1_valid_ff && adv && s1_in_range;
   assign req_fwd     = s1_write && (req_band == s1_band_ff);

   assign s1_valid_in = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_band_ff   <= req_band;
         s1_level_ff  <= req_level;
         s1_clear_ff  <= req_clear;
         rd_ff        <= mem[req_addr];
         rd_vld_ff    <= vld_ff[req_addr];
         fwd_ff       <= req_fwd;
         fwd_state_ff <= new_state;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_write) begin
         mem[s1_addr] <= new_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (s1_write) begin
         vld_ff[s1_addr] <= 1'b1;
      end
   end

   always_comb begin
      if (fwd_ff) begin
         cur_state = fwd_state_ff;
      end else if (rd_vld_ff) begin
         cur_state = rd_ff;
      end else begin
         cur_state = '0;
      end
   end

   bpfm_band_update u_update (
      .cfg       (cfg_ff),
      .cur_state (cur_state),
      .level     (s1_level_ff),
      .clear     (s1_clear_ff),
      .new_state (new_state)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_band_ff <= s1_band_ff;
         rsp_bar_ff  <= s1_in_range ? new_state.bar  : '0;
         rsp_peak_ff <= s1_in_range ? new_state.peak : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_band_out   = rsp_band_ff;
   assign rsp_bar_level  = rsp_bar_ff;
   assign rsp_peak_level = rsp_peak_ff;

endmodule

### test/tb_bar_and_peak_falloff_meter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bar_and_peak_falloff_meter_core
// Self-checking bench for the per-band bar and peak falloff meter. A
// scoreboard tracks every band's bar, peak and hold counters and the
// register settings. It predicts each response and compares it, in order,
// with what the core returns. A directed opening covers clamping, clear,
// hold expiry and full scale changes. Random traffic then runs under nine
// register settings and three stall mixes.
// ----------------------------------------------------------------------------

module tb_bar_and_peak_falloff_meter_core;
   import bpfm_pkg::*;

   localparam int METER_BANDS = 32;

   typedef struct packed {
      logic [BAND_W-1:0] band;
      logic [LVL_W-1:0]  bar;
      logic [LVL_W-1:0]  peak;
   } meter_reading_type;

   typedef struct packed {
      logic [LVL_W-1:0]  lvl;
      logic [HOLD_W-1:0] hold;
   } kept_level_type;

   class meter_scoreboard;
      band_state_type    bands [METER_BANDS];
      cfg_type           cfg;
      meter_reading_type expected_readings [$];
      int unsigned       errors;
      int unsigned       num_requests;
      int unsigned       num_checked;

      function new();
         foreach (bands[i]) bands[i] = '0;
         cfg.bar_falloff  = RST_BAR_FALLOFF;
         cfg.bar_hold     = RST_BAR_HOLD;
         cfg.peak_falloff = RST_PEAK_FALLOFF;
         cfg.peak_hold    = RST_PEAK_HOLD;
         cfg.full_scale   = RST_FULL_SCALE;
         errors       = 0;
         num_requests = 0;
         num_checked  = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_BAR_FALLOFF:  cfg.bar_falloff  = data[HOLD_W-1:0];
            CSR_BAR_HOLD:     cfg.bar_hold     = data[HOLD_W-1:0];
            CSR_PEAK_FALLOFF: cfg.peak_falloff = data[HOLD_W-1:0];
            CSR_PEAK_HOLD:    cfg.peak_hold    = data[HOLD_W-1:0];
            CSR_FULL_SCALE:   cfg.full_scale   = data;
            default: ;
         endcase
      endfunction

      // decay by falloff minus hold, count hold down, then rise if above
      function kept_level_type fall_and_rise(kept_level_type k, int unsigned x,
                                             int unsigned falloff, int unsigned reload);
         int unsigned h;
         int unsigned cur;
         int unsigned drop;
         kept_level_type r;
         h    = k.hold;
         cur  = k.lvl;
         drop = (falloff > h) ? falloff - h : 0;
         cur  = (cur > drop) ? cur - drop : 0;
         if (h != 0) h = h - 1;
         if (x > cur) begin
            cur = x;
            h   = reload;
         end
         r.lvl  = cur[LVL_W-1:0];
         r.hold = h[HOLD_W-1:0];
         return r;
      endfunction

      function void note_request(logic [BAND_W-1:0] band,
                                 logic signed [LEVEL_W-1:0] level, logic clear);
         meter_reading_type r;
         kept_level_type    k;
         int unsigned       x;
         r.band = band;
         r.bar  = '0;
         r.peak = '0;
         num_requests++;
         if (band < METER_BANDS) begin
            if (clear) begin
               bands[band] = '0;
            end else begin
               if (level[LEVEL_W-1]) x = 0;
               else x = level[LEVEL_W-2:0];
               if (x > cfg.full_scale) x = cfg.full_scale;
               k = fall_and_rise({bands[band].bar, bands[band].bar_hold}, x,
                                 cfg.bar_falloff, cfg.bar_hold);
               bands[band].bar      = k.lvl;
               bands[band].bar_hold = k.hold;
               k = fall_and_rise({bands[band].peak, bands[band].peak_hold}, x,
                                 cfg.peak_falloff, cfg.peak_hold);
               bands[band].peak      = k.lvl;
               bands[band].peak_hold = k.hold;
               r.bar  = bands[band].bar;
               r.peak = bands[band].peak;
            end
         end
         expected_readings.push_back(r);
      endfunction

      function void check_response(logic [BAND_W-1:0] band, logic [LVL_W-1:0] bar,
                                   logic [LVL_W-1:0] peak);
         meter_reading_type e;
         if (expected_readings.size() == 0) begin
            errors++;
            $display("%0t: unexpected response band %0d bar %0d peak %0d",
                     $time, band, bar, peak);
            return;
         end
         e = expected_readings.pop_front();
         num_checked++;
         if (band !== e.band) begin
            errors++;
            $display("%0t: band_out expected %0d actual %0d", $time, e.band, band);
         end
         if (bar !== e.bar) begin
            errors++;
            $display("%0t: bar_level band %0d expected %0d actual %0d",
                     $time, e.band, e.bar, bar);
         end
         if (peak !== e.peak) begin
            errors++;
            $display("%0t: peak_level band %0d expected %0d actual %0d",
                     $time, e.band, e.peak, peak);
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 6;
   localparam int ITEMS_PER_SEG = 183;

   logic                        clock;
   logic                        reset       = 1'b1;
   logic                        req_valid   = 1'b0;
   logic                        req_stall;
   logic [BAND_W-1:0]           req_band    = '0;
   logic signed [LEVEL_W-1:0]   req_level   = '0;
   logic                        req_clear   = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall   = 1'b0;
   logic [BAND_W-1:0]           rsp_band_out;
   logic [LVL_W-1:0]            rsp_bar_level;
   logic [LVL_W-1:0]            rsp_peak_level;
   logic                        csr_valid   = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index   = '0;
   logic [CSR_DATA_W-1:0]       csr_data    = '0;

   meter_scoreboard meter;
   int unsigned     req_idle_pct  = 0;
   int unsigned     rsp_stall_pct = 0;
   int unsigned     cycles        = 0;

   bar_and_peak_falloff_meter_core #(
      .NUM_BANDS(METER_BANDS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_band       (req_band),
      .req_level      (req_level),
      .req_clear      (req_clear),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_band_out   (rsp_band_out),
      .rsp_bar_level  (rsp_bar_level),
      .rsp_peak_level (rsp_peak_level),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  meter.expected_readings.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         meter.check_response(rsp_band_out, rsp_bar_level, rsp_peak_level);
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // valid stays high into the next transaction unless a gap is drawn
   task automatic send_req(input logic [BAND_W-1:0] band, input logic signed [LEVEL_W-1:0] level,
                           input logic clear);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_band  <= band;
      req_level <= level;
      req_clear <= clear;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      meter.note_request(band, level, clear);
   endtask

   task automatic send_random_req();
      logic [31:0]               rnd;
      logic [BAND_W-1:0]         band;
      logic signed [LEVEL_W-1:0] level;
      int unsigned               sel;
      rnd  = $urandom;
      sel  = $urandom_range(0, 99);
      if (sel < 20) band = {{(BAND_W-1){1'b0}}, rnd[16]};
      else band = rnd[20:16];
      sel = $urandom_range(0, 99);
      if (sel < 60) level = LEVEL_W'($urandom_range(0, 300));
      else if (sel < 72) level = rnd[15:0] | 16'h8000;
      else if (sel < 82) level = '0;
      else level = rnd[15:0];
      send_req(band, level, $urandom_range(0, 99) < 3);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      meter.write_reg(idx, data);
   endtask

   task automatic drain_meter();
      req_valid <= 1'b0;
      while (meter.expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_setting(int seg, logic is_scale);
      logic [31:0] rnd;
      rnd = $urandom;
      if (seg == 0) return 8'hff;
      if (seg == 1) return is_scale ? 8'd1 : 8'd0;
      case (rnd[1:0])
         2'd0:    return is_scale ? 8'd1 : 8'd0;
         2'd1:    return 8'hff;
         2'd2:    return rnd[15:8] & 8'hcf;
         default: return rnd[15:8];
      endcase
   endfunction

   task automatic program_meter(input int seg);
      logic [31:0] rnd;
      rnd = $urandom;
      write_csr(CSR_BAR_FALLOFF,  pick_setting(seg, 1'b0));
      write_csr(CSR_BAR_HOLD,     pick_setting(seg, 1'b0));
      write_csr(CSR_PEAK_FALLOFF, pick_setting(seg, 1'b0));
      write_csr(CSR_PEAK_HOLD,    pick_setting(seg, 1'b0));
      write_csr(CSR_FULL_SCALE,   pick_setting(seg, 1'b1));
      write_csr(CSR_IDX_W'(CSR_FULL_SCALE + 1 + rnd[9:8] % 3), rnd[7:0]);
      csr_valid <= 1'b0;
   endtask

   initial begin
      meter = new();
      req_idle_pct  = 15;
      rsp_stall_pct = 88;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: clamping at both ends of the level range, clear, hold expiry
      send_req(5'd0, 16'sd40, 1'b0);
      send_req(5'd0, 16'sh7fff, 1'b0);
      send_req(5'd0, 16'sh8000, 1'b0);
      send_req(5'd0, -16'sd1, 1'b0);
      send_req(5'd0, 16'sd0, 1'b0);
      send_req(5'd31, 16'sh7fff, 1'b0);
      send_req(5'd31, 16'sd25, 1'b1);
      send_req(5'd31, 16'sd5, 1'b0);
      send_req(5'd16, 16'sd1, 1'b0);
      send_req(5'd15, 16'sh0100, 1'b0);
      drain_meter();
      // full scale below the kept levels, masked data, writes off the map
      write_csr(CSR_FULL_SCALE, 8'd10);
      write_csr(CSR_BAR_FALLOFF, 8'hff);
      for (int i = CSR_FULL_SCALE + 1; i < (1 << CSR_IDX_W); i++)
         write_csr(CSR_IDX_W'(i), 8'h5a);
      csr_valid <= 1'b0;
      send_req(5'd0, 16'sd3, 1'b0);
      send_req(5'd0, 16'sd10, 1'b0);
      send_req(5'd0, 16'sd11, 1'b0);
      drain_meter();
      write_csr(CSR_FULL_SCALE, 8'd0);
      csr_valid <= 1'b0;
      send_req(5'd1, 16'sd100, 1'b0);
      send_req(5'd1, 16'sd1, 1'b0);
      drain_meter();
      write_csr(CSR_FULL_SCALE, 8'd255);
      write_csr(CSR_PEAK_HOLD, 8'd63);
      write_csr(CSR_BAR_HOLD, 8'd0);
      write_csr(CSR_PEAK_FALLOFF, 8'd63);
      csr_valid <= 1'b0;
      send_req(5'd2, 16'sd255, 1'b0);
      send_req(5'd2, 16'sd256, 1'b0);
      send_req(5'd2, 16'sd0, 1'b0);
      send_req(5'd2, 16'sd0, 1'b0);
      send_req(5'd2, 16'sd0, 1'b1);
      send_req(5'd2, 16'sd7, 1'b0);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct  = 15;
               rsp_stall_pct = 88;
            end
            1: begin
               req_idle_pct  = 88;
               rsp_stall_pct = 15;
            end
            default: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 3; seg++) begin
            drain_meter();
            program_meter(phase * 3 + seg);
            repeat (ITEMS_PER_SEG) send_random_req();
         end
      end
      drain_meter();

      $display("Checked %0d responses for %0d requests in %0d cycles, %0d mismatches",
               meter.num_checked, meter.num_requests, cycles, meter.errors);
      $display("Covered clamping, clear, hold and falloff over nine settings, three stall mixes");
      if (meter.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
